[rtl/ffba_pkg.sv]
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

  localparam int NUM_BLOCKS_DEF  = 16;
  localparam int SIZE_WIDTH_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int BIU_W    = 5;
  localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // Command word passed from front to back through the queue.
  typedef struct packed {
    logic              is_req;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RD,
    BK_CMP,
    BK_EMIT
  } bk_state_t;

endpackage

[rtl/first_fit_block_allocator_unit.sv]
// Top level of the first-fit block allocator: front, queue, back and config register.
//
// First-fit allocator over a table of NUM_BLOCKS free capacities (SIZE_WIDTH bits
// each, all zero after reset). A load word (mode 0) writes one block's capacity
// and gives no result; a load to a slot beyond the table is dropped. A request
// word (mode 1) scans blocks 0 upward, up to blocks_in_use (clamped to
// NUM_BLOCKS), takes the first with capacity >= amount, subtracts the amount and
// returns granted with the block index; if none fits it returns not granted,
// index 0, table untouched. The front takes one word per cycle while the
// two-entry queue has room. The back handles a load in its idle state; a
// request passes through a RAM read state and a compare state for each block
// searched on the single table RAM, then an emit state that waits for the
// output register to be free. A finished result sits in the output register
// while the back takes the next word. cfg_data is written at any time but is
// only meant to change while the block is idle.
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // config word
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BIU_W-1:0]    cfg_data,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [SLOT_W-1:0]   in_block_slot,
  input  logic [AMOUNT_W-1:0] in_amount,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_granted,
  output logic [SLOT_W-1:0]   out_chosen_block
);

  localparam int Q_W   = $bits(cmd_t) + SIZE_WIDTH;
  localparam int CNT_W = $clog2(QUEUE_DEPTH_DEF + 1);

  logic [BIU_W-1:0] blocks_in_use_r, blocks_in_use_nxt;

  logic                  push_valid, push_ready;
  cmd_t                  push_cmd;
  logic [SIZE_WIDTH-1:0] push_amount;
  logic                  pop_valid, pop_ready;
  logic [Q_W-1:0]        pop_data;
  cmd_t                  pop_cmd;
  logic [SIZE_WIDTH-1:0] pop_amount;
  logic [CNT_W-1:0]      q_count;

  // config register: always ready, one word per cycle
  assign cfg_ready = 1'b1;

  always_comb begin
    blocks_in_use_nxt = blocks_in_use_r;
    if (cfg_valid && cfg_ready) begin
      blocks_in_use_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_in_use_r <= BIU_RESET;
    end else begin
      blocks_in_use_r <= blocks_in_use_nxt;
    end
  end

  ffba_front #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_block_slot (in_block_slot),
    .in_amount     (in_amount),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd),
    .push_amount   (push_amount)
  );

  ffba_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_cmd, push_amount}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .count      (q_count)
  );

  assign pop_cmd    = pop_data[Q_W-1:SIZE_WIDTH];
  assign pop_amount = pop_data[SIZE_WIDTH-1:0];

  ffba_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .blocks_in_use    (blocks_in_use_r),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_cmd          (pop_cmd),
    .pop_amount       (pop_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block)
  );

  // refused requests carry index zero
  a_refused_index_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_chosen_block == '0)
  ) else $error("refused result with non-zero block index");

  // a granted block lies inside the searched range
  a_grant_in_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |->
      ((32'(out_chosen_block) < 32'(blocks_in_use_r)) &&
       (32'(out_chosen_block) < NUM_BLOCKS))
  ) else $error("granted block outside searched range");

  // queue occupancy bounded; front stalls only when full
  a_queue_bound: assert property (
    @(posedge clk) disable iff (!rst_n)
    (32'(q_count) <= QUEUE_DEPTH_DEF) &&
      (in_ready || (32'(q_count) == QUEUE_DEPTH_DEF))
  ) else $error("queue occupancy out of bounds");

  // after a pop the queue is below full, unless a word was offered in the same cycle
  a_back_drains: assert property (
    @(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> (32'(q_count) < QUEUE_DEPTH_DEF) || $past(push_valid)
  ) else $error("queue did not drain after pop");

endmodule

[rtl/ffba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffba_ram
  import ffba_pkg::*;
#(
  parameter int WIDTH = SIZE_WIDTH_DEF,
  parameter int DEPTH = NUM_BLOCKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/ffba_front.sv]
// Front end: accepts input words, drops out-of-range loads, sizes the amount.
module ffba_front
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [SLOT_W-1:0]     in_block_slot,
  input  logic [AMOUNT_W-1:0]   in_amount,
  output logic                  push_valid,
  input  logic                  push_ready,
  output cmd_t                  push_cmd,
  output logic [SIZE_WIDTH-1:0] push_amount
);

  localparam int CMP_W = ($clog2(NUM_BLOCKS + 1) > SLOT_W + 1) ?
                         $clog2(NUM_BLOCKS + 1) : SLOT_W + 1;

  logic [CMP_W-1:0] slot_ext;
  logic             drop;

  assign slot_ext = CMP_W'(in_block_slot);
  // a load to a slot beyond the table does nothing
  assign drop     = (in_mode == MODE_LOAD) && (slot_ext >= CMP_W'(NUM_BLOCKS));

  assign in_ready        = push_ready;
  assign push_valid      = in_valid && !drop;
  assign push_cmd.is_req = (in_mode == MODE_REQUEST);
  assign push_cmd.slot   = in_block_slot;
  assign push_amount     = SIZE_WIDTH'(in_amount);

endmodule

[rtl/ffba_queue.sv]
// Small FIFO between front and back.
module ffba_queue
  import ffba_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push_valid,
  output logic                         push_ready,
  input  logic [WIDTH-1:0]             push_data,
  output logic                         pop_valid,
  input  logic                         pop_ready,
  output logic [WIDTH-1:0]             pop_data,
  output logic [$clog2(DEPTH + 1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign count      = count_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/ffba_back.sv]
// Back end: capacity table, first-fit scan and result register.
module ffba_back
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [BIU_W-1:0]      blocks_in_use,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  cmd_t                  pop_cmd,
  input  logic [SIZE_WIDTH-1:0] pop_amount,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_granted,
  output logic [SLOT_W-1:0]     out_chosen_block
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CMP_W = ($clog2(NUM_BLOCKS + 1) > BIU_W) ?
                         $clog2(NUM_BLOCKS + 1) : BIU_W;

  bk_state_t state_r, state_nxt;

  logic [CMP_W-1:0]      k_r, k_nxt;
  logic [CMP_W-1:0]      limit_r, limit_nxt;
  logic [SIZE_WIDTH-1:0] amt_r, amt_nxt;
  logic                  res_granted_r, res_granted_nxt;
  logic [SLOT_W-1:0]     res_chosen_r, res_chosen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_granted_r, out_granted_nxt;
  logic [SLOT_W-1:0]     out_chosen_r, out_chosen_nxt;
  logic [NUM_BLOCKS-1:0] valid_r, valid_nxt;

  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [SIZE_WIDTH-1:0] wr_data, rd_data, cap;
  logic [IDX_W-1:0]      k_idx, slot_idx;
  logic [CMP_W-1:0]      biu_ext, slot_ext;
  logic                  fits, out_free;

  ffba_ram #(
    .WIDTH (SIZE_WIDTH),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (k_idx),
    .rd_data (rd_data)
  );

  assign k_idx    = k_r[IDX_W-1:0];
  assign slot_ext = CMP_W'(pop_cmd.slot);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign biu_ext  = CMP_W'(blocks_in_use);
  // entries never loaded read as zero
  assign cap      = valid_r[k_idx] ? rd_data : '0;
  assign fits     = (cap >= amt_r);
  assign out_free = !out_valid_r || out_ready;
  assign pop_ready = (state_r == BK_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop_valid && pop_cmd.is_req) begin
          state_nxt = BK_RD;
        end
      end
      BK_RD: begin
        state_nxt = (k_r == limit_r) ? BK_EMIT : BK_CMP;
      end
      BK_CMP: begin
        state_nxt = fits ? BK_EMIT : BK_RD;
      end
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    k_nxt           = k_r;
    limit_nxt       = limit_r;
    amt_nxt         = amt_r;
    res_granted_nxt = res_granted_r;
    res_chosen_nxt  = res_chosen_r;
    out_granted_nxt = out_granted_r;
    out_chosen_nxt  = out_chosen_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    valid_nxt       = valid_r;
    wr_en           = 1'b0;
    wr_addr         = slot_idx;
    wr_data         = pop_amount;
    rd_en           = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          if (pop_cmd.is_req) begin
            amt_nxt   = pop_amount;
            k_nxt     = '0;
            limit_nxt = (biu_ext > CMP_W'(NUM_BLOCKS)) ? CMP_W'(NUM_BLOCKS) : biu_ext;
          end else begin
            wr_en               = 1'b1;
            valid_nxt[slot_idx] = 1'b1;
          end
        end
      end
      BK_RD: begin
        if (k_r == limit_r) begin
          res_granted_nxt = 1'b0;
          res_chosen_nxt  = '0;
        end else begin
          rd_en = 1'b1;
        end
      end
      BK_CMP: begin
        if (fits) begin
          wr_en            = 1'b1;
          wr_addr          = k_idx;
          wr_data          = cap - amt_r;
          valid_nxt[k_idx] = 1'b1;
          res_granted_nxt  = 1'b1;
          res_chosen_nxt   = k_r[SLOT_W-1:0];
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_granted_r;
          out_chosen_nxt  = res_chosen_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    limit_r       <= limit_nxt;
    amt_r         <= amt_nxt;
    res_granted_r <= res_granted_nxt;
    res_chosen_r  <= res_chosen_nxt;
    out_granted_r <= out_granted_nxt;
    out_chosen_r  <= out_chosen_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_chosen_block = out_chosen_r;

endmodule

[verif/ffba_checker.sv]
// Checker for the first-fit block allocator: watches the word channels, predicts results, compares.
module ffba_checker
  import ffba_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [BIU_W-1:0]    cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_mode,
  input  logic [SLOT_W-1:0]   in_block_slot,
  input  logic [AMOUNT_W-1:0] in_amount,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_granted,
  input  logic [SLOT_W-1:0]   out_chosen_block,
  output int                  fail_count,
  output int                  pending,
  output int                  loads_seen,
  output int                  grants_seen,
  output int                  refusals_seen,
  output int                  len_writes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] block;
  } grant_t;

  logic [AMOUNT_W-1:0] capacity [NUM_BLOCKS_DEF];
  logic [BIU_W-1:0]    search_len;
  grant_t              due_grants [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    loads_seen    = 0;
    grants_seen   = 0;
    refusals_seen = 0;
    len_writes    = 0;
  end

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // First block in the searched range that holds the size; it loses that much.
  function automatic grant_t first_fit(input logic [AMOUNT_W-1:0] size);
    grant_t g;
    int     n;
    g = '0;
    n = (search_len > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(search_len);
    for (int k = 0; k < n; k++) begin
      if (capacity[k] >= size) begin
        capacity[k] = capacity[k] - size;
        g.granted   = 1'b1;
        g.block     = SLOT_W'(k);
        break;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      for (int k = 0; k < NUM_BLOCKS_DEF; k++) capacity[k] = '0;
      search_len = BIU_RESET;
      due_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        search_len = cfg_data;
        len_writes++;
      end
      if (in_valid && in_ready) begin
        if (in_mode == MODE_LOAD) begin
          capacity[in_block_slot] = in_amount;
          loads_seen++;
        end else begin
          due_grants.push_back(first_fit(in_amount));
        end
      end
      if (out_valid && out_ready) begin
        if (due_grants.size() == 0) begin
          note_mismatch($sformatf("result word with nothing due (granted %0b block %0d)",
                                  out_granted, out_chosen_block));
        end else begin
          want = due_grants.pop_front();
          if (out_granted !== want.granted)
            note_mismatch($sformatf("granted %0b, predicted %0b", out_granted, want.granted));
          if (out_chosen_block !== want.block)
            note_mismatch($sformatf("chosen_block %0d, predicted %0d",
                                    out_chosen_block, want.block));
          if (want.granted) grants_seen++;
          else refusals_seen++;
        end
      end
    end
    pending = due_grants.size();
  end

endmodule

[verif/tb_top.sv]
// Top of the first-fit block allocator testbench: stimulus, flow control and verdict.
module tb_top
  import ffba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Settle time before a search-length write, long enough to comfortably cover a
  // word still in flight through the queue and the back's first-fit search.
  localparam int SETTLE_CYCLES   = 60;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int PHASE_WORDS     = 55;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                cfg_valid        = 1'b0;
  logic                cfg_ready;
  logic [BIU_W-1:0]    cfg_data         = '0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic                in_mode          = MODE_LOAD;
  logic [SLOT_W-1:0]   in_block_slot    = '0;
  logic [AMOUNT_W-1:0] in_amount        = '0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic                out_granted;
  logic [SLOT_W-1:0]   out_chosen_block;

  int fail_count, pending, loads_seen, grants_seen, refusals_seen, len_writes;

  // calm: no idling on either side; hold_off_req: ask the sink for one long stall
  logic calm          = 1'b0;
  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;
  int   stall_cycles  = 0;

  always #5 clk = ~clk;

  first_fit_block_allocator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_block_slot    (in_block_slot),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block)
  );

  ffba_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_block_slot    (in_block_slot),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block),
    .fail_count       (fail_count),
    .pending          (pending),
    .loads_seen       (loads_seen),
    .grants_seen      (grants_seen),
    .refusals_seen    (refusals_seen),
    .len_writes       (len_writes)
  );

  // Result sink. Mostly ready, with random stall bursts; once on request it
  // holds off for a long stretch so the queue fills and in_ready drops.
  always begin : sink_flow
    int gap;
    @(negedge clk);
    if (hold_off_req && !hold_off_done) begin
      out_ready <= 1'b0;
      repeat (HOLD_OFF_CYCLES) @(negedge clk);
      hold_off_done = 1'b1;
      out_ready <= 1'b1;
    end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      out_ready <= 1'b0;
      repeat (gap) @(negedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: cycles with no word moving on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results still due",
                 WATCHDOG_LIMIT, pending);
        $display("first_fit_block_allocator_unit regression: fail");
        $finish;
      end
    end
  end

  // Offer one input word from a falling edge; returns at the falling edge after
  // it is taken, leaving valid high so a following word needs no re-raise.
  task automatic send_word(input logic mode, input logic [SLOT_W-1:0] slot,
                           input logic [AMOUNT_W-1:0] amt);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_block_slot <= slot;
    in_amount     <= amt;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Search-length write, only once the block has drained.
  task automatic set_search_len(input logic [BIU_W-1:0] len);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random word: loads with a spread of capacities, requests sized so that
  // grants, refusals and the zero/full-scale edges all turn up.
  task automatic send_random_word();
    int                  pick;
    logic [AMOUNT_W-1:0] amt;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      amt = '0;
      else if (pick == 1) amt = '1;
      else if (pick < 5)  amt = AMOUNT_W'($urandom_range(0, 4000));
      else                amt = AMOUNT_W'($urandom);
      send_word(MODE_LOAD, SLOT_W'($urandom_range(0, 15)), amt);
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0)       amt = '0;
      else if (pick == 1)  amt = '1;
      else if (pick < 12)  amt = AMOUNT_W'($urandom_range(0, 3000));
      else if (pick < 17)  amt = AMOUNT_W'($urandom_range(0, 20000));
      else                 amt = AMOUNT_W'($urandom);
      // block_slot is don't-care on a request; random keeps it moving
      send_word(MODE_REQUEST, SLOT_W'($urandom_range(0, 15)), amt);
    end
  endtask

  initial begin
    logic [BIU_W-1:0] phase_len [8];
    int               phases_run;

    phase_len = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd12, 5'd16, 5'd16};
    phase_len[6] = BIU_W'($urandom_range(1, 16));

    // synchronous reset, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset search length of 16, empty table first.
    send_word(MODE_REQUEST, 4'd0,  16'd0);      // zero size fits block 0 even when empty
    send_word(MODE_REQUEST, 4'd0,  16'd1);      // empty table, refused
    send_word(MODE_LOAD,    4'd15, 16'hFFFF);
    send_word(MODE_LOAD,    4'd0,  16'd5);
    send_word(MODE_LOAD,    4'd3,  16'hAAAA);
    send_word(MODE_LOAD,    4'd7,  16'h5555);
    send_word(MODE_REQUEST, 4'd15, 16'hFFFF);   // only top block holds full scale
    send_word(MODE_REQUEST, 4'd0,  16'd5);      // exact fit empties block 0
    send_word(MODE_REQUEST, 4'd0,  16'd6);      // skips the drained block 0
    send_word(MODE_REQUEST, 4'd0,  16'd0);      // zero size, no change
    send_word(MODE_REQUEST, 4'd0,  16'hFFFF);   // nothing left that large
    send_word(MODE_REQUEST, 4'd9,  16'h5555);   // slot field ignored on a request
    send_word(MODE_LOAD,    4'd15, 16'h1234);
    send_word(MODE_LOAD,    4'd10, 16'd0);

    set_search_len(5'd0);                       // nothing searched
    send_word(MODE_REQUEST, 4'd0,  16'd0);
    send_word(MODE_REQUEST, 4'd5,  16'd1);

    set_search_len(5'd31);                      // clamps to the table size
    send_word(MODE_REQUEST, 4'd0,  16'h6000);   // no block holds that much, refused
    send_word(MODE_REQUEST, 4'd0,  16'h1234);   // first fit is block 3

    set_search_len(5'd1);                       // block 0 alone
    send_word(MODE_REQUEST, 4'd0,  16'd1);
    send_word(MODE_LOAD,    4'd0,  16'h0010);
    send_word(MODE_REQUEST, 4'd0,  16'h0010);
    send_word(MODE_REQUEST, 4'd0,  16'h5555);

    // Random phases over several search lengths. The first one asks for the
    // long sink hold-off; the last runs with no idling at all.
    phases_run = 0;
    foreach (phase_len[p]) begin
      set_search_len(phase_len[p]);
      phases_run++;
      if (p == 0) hold_off_req = 1'b1;
      if (p == 7) calm = 1'b1;
      repeat (PHASE_WORDS) send_random_word();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d loads and %0d requests (%0d granted, %0d refused)",
             loads_seen, grants_seen + refusals_seen, grants_seen, refusals_seen);
    $display("over %0d search-length writes incl. 0, 1, 31 and %0d random phases",
             len_writes, phases_run);
    if (fail_count == 0) begin
      $display("first_fit_block_allocator_unit regression: pass");
    end else begin
      $display("first_fit_block_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/ffba_front.sv
rtl/ffba_queue.sv
rtl/ffba_back.sv
rtl/first_fit_block_allocator_unit.sv
verif/ffba_checker.sv
verif/tb_top.sv
